[design/psl_pkg.sv]
package psl_pkg;

    // default sizing of the table
    localparam int DEF_MAX_SEGMENTS = 1024;
    localparam int DEF_SIZE_BITS    = 32;

    // fixed field widths
    localparam int ITEM_W = 32;
    localparam int ST_W   = 2;

    // request kinds
    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // controller to datapath commands
    typedef struct packed {
        logic start;   // transaction accepted: capture, append, set up search
        logic step;    // one lower-bound search step
        logic emit;    // move pending result to the output register
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic need_search;   // accepted query is in range
        logic search_done;   // search interval is empty after this step
    } stat_t;

endpackage

[design/prefix_sum_segment_locator_top.sv]
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | req_type, item_value
// out     | output    | out_valid / out_ready| segment_number, offset_in_segment, status
//
// an append writes the table at accept; its result is loaded in the finish state
// a query in range runs a lower-bound search between accept and the finish state;
// the search does one compare per cycle against the registered table read
// an out-of-range query skips the search; reset clears the count, total and handshake state
// the table memory holds no reset and needs no clearing pass
// a stalled output holds the finished result; the next transaction is taken meanwhile
module prefix_sum_segment_locator_top #(
    parameter int MAX_SEGMENTS = psl_pkg::DEF_MAX_SEGMENTS,
    parameter int SIZE_BITS    = psl_pkg::DEF_SIZE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [psl_pkg::ITEM_W-1:0]        item_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [$clog2(MAX_SEGMENTS+1)-1:0] segment_number,
    output logic [psl_pkg::ITEM_W-1:0]        offset_in_segment,
    output logic [psl_pkg::ST_W-1:0]          status
);

    import psl_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    psl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    psl_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .SIZE_BITS    (SIZE_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .req_type          (req_type),
        .item_value        (item_value),
        .segment_number    (segment_number),
        .offset_in_segment (offset_in_segment),
        .status            (status)
    );

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid || out_ready))
        else $error("result loaded over an untaken transaction");

    // commands are mutually exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.step, cmd.emit}))
        else $error("overlapping controller commands");

    // a located position has a nonzero offset
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK && segment_number != '0) |-> (offset_in_segment != '0))
        else $error("found segment with zero offset");

    // failures carry no segment or offset
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (segment_number == '0 && offset_in_segment == '0))
        else $error("failed transaction with nonzero payload");

endmodule

[design/psl_ram.sv]
module psl_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/psl_ctrl.sv]
module psl_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  psl_pkg::stat_t  stat,
    output psl_pkg::cmd_t   cmd
);

    import psl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = stat.need_search ? S_SEARCH : S_FINISH;
                end
            end
            S_SEARCH:
            begin
                cmd.step = 1'b1;
                if (stat.search_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register occupancy
    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[design/psl_dp.sv]
module psl_dp #(
    parameter int MAX_SEGMENTS = psl_pkg::DEF_MAX_SEGMENTS,
    parameter int SIZE_BITS    = psl_pkg::DEF_SIZE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  psl_pkg::cmd_t                     cmd,
    output psl_pkg::stat_t                    stat,
    input  logic                              req_type,
    input  logic [psl_pkg::ITEM_W-1:0]        item_value,
    output logic [$clog2(MAX_SEGMENTS+1)-1:0] segment_number,
    output logic [psl_pkg::ITEM_W-1:0]        offset_in_segment,
    output logic [psl_pkg::ST_W-1:0]          status
);

    import psl_pkg::*;

    localparam int IDX_W   = $clog2(MAX_SEGMENTS);
    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int TBL_W   = SIZE_BITS + IDX_W;
    localparam int CMP_W   = (TBL_W > ITEM_W) ? TBL_W : ITEM_W;
    localparam int SZ_IN_W = (SIZE_BITS < ITEM_W) ? SIZE_BITS : ITEM_W;

    // table bookkeeping
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [TBL_W-1:0]  total_reg;
    logic [TBL_W-1:0]  total_next;

    // search state
    logic [ITEM_W-1:0] pos_reg;
    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  lo_next;
    logic [CNT_W-1:0]  hi_reg;
    logic [CNT_W-1:0]  hi_next;
    logic [CNT_W-1:0]  mid_reg;
    logic [CNT_W-1:0]  mid_next;
    logic [TBL_W-1:0]  start_reg;
    logic [TBL_W-1:0]  start_next;

    // pending and output results
    status_t           st_reg;
    status_t           st_next;
    logic              found_reg;
    logic              found_next;
    logic [CNT_W-1:0]  seg_out_reg;
    logic [ITEM_W-1:0] off_out_reg;
    status_t           st_out_reg;

    logic              is_query;
    logic              table_full;
    logic              pos_in_range;
    logic [TBL_W-1:0]  size_ext;
    logic [TBL_W-1:0]  sum_new;
    logic              ram_we;
    logic [TBL_W-1:0]  rdata;
    logic              below;

    // request decode
    assign is_query     = (req_type == REQ_QUERY);
    assign table_full   = (count_reg == CNT_W'(MAX_SEGMENTS));
    assign size_ext     = TBL_W'(item_value[SZ_IN_W-1:0]);
    assign sum_new      = total_reg + size_ext;
    assign pos_in_range = (item_value != '0) && (CMP_W'(item_value) <= CMP_W'(total_reg));
    assign ram_we       = cmd.start && !is_query && !table_full;

    // append bookkeeping
    always_comb
    begin
        count_next = count_reg;
        total_next = total_reg;
        if (ram_we)
        begin
            count_next = count_reg + CNT_W'(1);
            total_next = sum_new;
        end
    end

    // lower-bound step: entry below the position moves lo past mid
    assign below = (CMP_W'(rdata) < CMP_W'(pos_reg));

    always_comb
    begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        start_next = start_reg;
        if (cmd.start)
        begin
            lo_next    = '0;
            hi_next    = count_reg;
            start_next = '0;
        end
        else if (cmd.step)
        begin
            if (below)
            begin
                lo_next    = mid_reg + CNT_W'(1);
                start_next = rdata;
            end
            else
            begin
                hi_next = mid_reg;
            end
        end
        mid_next = lo_next + ((hi_next - lo_next) >> 1);
    end

    assign stat.need_search = is_query && pos_in_range;
    assign stat.search_done = !(lo_next < hi_next);

    // result classification at accept
    always_comb
    begin
        st_next    = st_reg;
        found_next = found_reg;
        if (cmd.start)
        begin
            if (!is_query)
            begin
                st_next    = table_full ? ST_FULL : ST_OK;
                found_next = 1'b0;
            end
            else if (pos_in_range)
            begin
                st_next    = ST_OK;
                found_next = 1'b1;
            end
            else
            begin
                st_next    = ST_RANGE;
                found_next = 1'b0;
            end
        end
    end

    psl_ram #(
        .WIDTH (TBL_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (sum_new),
        .raddr (mid_next[IDX_W-1:0]),
        .rdata (rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    // search and result payload
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        start_reg <= start_next;
        st_reg    <= st_next;
        found_reg <= found_next;
        if (cmd.start)
        begin
            pos_reg <= item_value;
        end
        if (cmd.emit)
        begin
            seg_out_reg <= found_reg ? (lo_reg + CNT_W'(1)) : '0;
            off_out_reg <= found_reg ? (pos_reg - ITEM_W'(start_reg)) : '0;
            st_out_reg  <= st_reg;
        end
    end

    assign segment_number    = seg_out_reg;
    assign offset_in_segment = off_out_reg;
    assign status            = st_out_reg;

endmodule
